[sv/tsr_pkg.sv]
// shared types, constants and codes for the transport segment reassembler
// no dependencies
`default_nettype none

package tsr_pkg;

    localparam int FRAG_SIZE_DEF   = 2048;
    localparam int MAX_SEGMENT_DEF = 250;
    localparam int MIN_SEGMENT     = 2;
    localparam int STAGE_DEPTH     = 256;
    localparam int STAGE_AW        = 8;
    localparam int COUNT_MAX       = 511;
    localparam int SEG_CNT_W       = 9;
    localparam int SEQ_W           = 6;
    localparam int POS_W           = 17;
    localparam int LEN_OUT_W       = 12;
    localparam int IDX_W           = 11;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [1:0] CMD_SEGMENT = 2'd0;
    localparam logic [1:0] CMD_RESET   = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [3:0] ST_TAKEN      = 4'd0;
    localparam logic [3:0] ST_APPENDED   = 4'd1;
    localparam logic [3:0] ST_DONE       = 4'd2;
    localparam logic [3:0] ST_NO_PAYLOAD = 4'd3;
    localparam logic [3:0] ST_TOO_LONG   = 4'd4;
    localparam logic [3:0] ST_FULL       = 4'd5;
    localparam logic [3:0] ST_NO_FIR     = 4'd6;
    localparam logic [3:0] ST_BAD_SEQ    = 4'd7;
    localparam logic [3:0] ST_RESET      = 4'd8;
    localparam logic [3:0] ST_READ       = 4'd9;

    localparam logic [1:0] JOB_EMIT = 2'd0;
    localparam logic [1:0] JOB_COPY = 2'd1;
    localparam logic [1:0] JOB_READ = 2'd2;

    typedef struct packed {
        logic [1:0]           kind;
        logic [3:0]           status;
        logic                 fir_discarded;
        logic [LEN_OUT_W-1:0] fragment_length;
        logic [POS_W-1:0]     copy_base;
        logic [7:0]           copy_len;
        logic [IDX_W-1:0]     read_index;
    } job_t;

    typedef struct packed {
        logic                rd_en;
        logic [STAGE_AW-1:0] rd_addr;
        logic                copy_done;
    } stage_req_t;

endpackage

`default_nettype wire

[sv/tsr_front.sv]
// front end: takes segment bytes, keeps the staging store and judges segments
// depends on tsr_pkg
`default_nettype none

module tsr_front
    import tsr_pkg::*;
#(
    parameter int FRAG_SIZE   = FRAG_SIZE_DEF,
    parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,
    input  logic [2:0]  s_tuser,
    output logic        push_valid,
    output job_t        push_job,
    input  logic        queue_full,
    input  stage_req_t  stage_req,
    output logic [7:0]  stage_rd_data
);

    localparam int CNT_W = $clog2(FRAG_SIZE + 1);

    logic [CNT_W-1:0]     asm_reg, asm_next;
    logic [SEQ_W-1:0]     exp_reg, exp_next;
    logic [7:0]           hdr_reg, hdr_next;
    logic [SEG_CNT_W-1:0] seg_cnt_reg, seg_cnt_next;
    logic                 copy_busy_reg, copy_busy_next;

    logic [7:0] stage_mem [STAGE_DEPTH];

    logic [1:0]           cmd;
    logic                 accept;
    logic                 stage_we;
    logic [STAGE_AW-1:0]  stage_wa;
    logic [7:0]           hdr_cur;
    logic [SEG_CNT_W-1:0] cnt_cur;
    logic                 seg_open;
    logic [CNT_W-1:0]     asm_eff;
    logic [SEQ_W-1:0]     exp_eff;
    logic [7:0]           payload;
    logic [CNT_W:0]       fit_sum;
    logic [SEG_CNT_W-1:0] cnt_dec;

    assign cmd      = s_tuser[1:0];
    assign s_tready = !queue_full && !copy_busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign cnt_dec  = seg_cnt_reg - 1'b1;
    assign stage_wa = cnt_dec[STAGE_AW-1:0];

    always_comb begin
        asm_next       = asm_reg;
        exp_next       = exp_reg;
        hdr_next       = hdr_reg;
        seg_cnt_next   = seg_cnt_reg;
        copy_busy_next = copy_busy_reg && !stage_req.copy_done;
        push_job       = '0;
        push_job.kind  = JOB_EMIT;
        stage_we       = 1'b0;
        hdr_cur        = hdr_reg;
        cnt_cur        = seg_cnt_reg;
        seg_open       = 1'b1;
        asm_eff        = asm_reg;
        exp_eff        = exp_reg;
        payload        = '0;
        fit_sum        = '0;
        if (accept) begin
            case (cmd)
                CMD_RESET: begin
                    asm_next        = '0;
                    exp_next        = '0;
                    seg_cnt_next    = '0;
                    push_job.status = ST_RESET;
                end
                CMD_READ: begin
                    push_job.kind       = JOB_READ;
                    push_job.status     = ST_READ;
                    push_job.read_index = s_tdata[18:8];
                end
                CMD_SEGMENT: begin
                    if (s_tuser[2]) begin
                        hdr_cur = s_tdata[7:0];
                        cnt_cur = SEG_CNT_W'(1);
                    end else if (seg_cnt_reg == '0) begin
                        seg_open = 1'b0;
                    end else begin
                        stage_we = (seg_cnt_reg <= SEG_CNT_W'(STAGE_DEPTH));
                        if (seg_cnt_reg < SEG_CNT_W'(COUNT_MAX)) begin
                            cnt_cur = seg_cnt_reg + 1'b1;
                        end
                    end
                    hdr_next     = hdr_cur;
                    seg_cnt_next = cnt_cur;
                    if (seg_open && s_tlast) begin
                        seg_cnt_next = '0;
                        payload      = 8'(cnt_cur - 1'b1);
                        if (cnt_cur < SEG_CNT_W'(MIN_SEGMENT)) begin
                            push_job.status = ST_NO_PAYLOAD;
                        end else if (cnt_cur > SEG_CNT_W'(MAX_SEGMENT)) begin
                            push_job.status = ST_TOO_LONG;
                        end else if (!hdr_cur[6] && asm_reg == '0) begin
                            push_job.status = ST_NO_FIR;
                        end else begin
                            if (hdr_cur[6]) begin
                                exp_eff = hdr_cur[5:0];
                                asm_eff = '0;
                                push_job.fir_discarded = (asm_reg != '0);
                            end
                            exp_next = exp_eff;
                            asm_next = asm_eff;
                            fit_sum  = {1'b0, asm_eff} + (CNT_W + 1)'(payload);
                            if (hdr_cur[5:0] != exp_eff) begin
                                push_job.status = ST_BAD_SEQ;
                            end else if (fit_sum > (CNT_W + 1)'(FRAG_SIZE)) begin
                                asm_next        = '0;
                                push_job.status = ST_FULL;
                            end else begin
                                push_job.kind      = JOB_COPY;
                                push_job.copy_base = POS_W'(asm_eff);
                                push_job.copy_len  = payload;
                                copy_busy_next     = 1'b1;
                                exp_next           = exp_eff + 1'b1;
                                asm_next           = fit_sum[CNT_W-1:0];
                                push_job.status    = ST_APPENDED;
                                if (hdr_cur[7]) begin
                                    push_job.status          = ST_DONE;
                                    push_job.fragment_length = LEN_OUT_W'(fit_sum[CNT_W-1:0]);
                                    asm_next                 = '0;
                                end
                            end
                        end
                    end
                end
                default: begin
                    push_job.status = ST_TAKEN;
                end
            endcase
        end
    end

    assign push_valid = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asm_reg       <= '0;
            exp_reg       <= '0;
            hdr_reg       <= '0;
            seg_cnt_reg   <= '0;
            copy_busy_reg <= 1'b0;
        end else begin
            asm_reg       <= asm_next;
            exp_reg       <= exp_next;
            hdr_reg       <= hdr_next;
            seg_cnt_reg   <= seg_cnt_next;
            copy_busy_reg <= copy_busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_we) begin
            stage_mem[stage_wa] <= s_tdata[7:0];
        end
        if (stage_req.rd_en) begin
            stage_rd_data <= stage_mem[stage_req.rd_addr];
        end
    end

    a_asm_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        asm_reg <= CNT_W'(FRAG_SIZE))
        else $error("assembled count beyond fragment size");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !queue_full)
        else $error("request pushed into a full queue");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_req.copy_done |-> copy_busy_reg)
        else $error("copy done with no copy outstanding");

endmodule

`default_nettype wire

[sv/tsr_queue.sv]
// short job queue between the front end and the back end
// depends on tsr_pkg
`default_nettype none

module tsr_queue
    import tsr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t            entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

`default_nettype wire

[sv/tsr_back.sv]
// back end: copies staged payload into the fragment store, serves reads,
// holds the result register; depends on tsr_pkg
`default_nettype none

module tsr_back
    import tsr_pkg::*;
#(
    parameter int FRAG_SIZE = FRAG_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        queue_empty,
    input  job_t        pop_job,
    output logic        pop,
    output stage_req_t  stage_req,
    input  logic [7:0]  stage_rd_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic [3:0]  m_tuser
);

    localparam int AW = $clog2(FRAG_SIZE);

    localparam logic [1:0] BK_IDLE  = 2'd0;
    localparam logic [1:0] BK_COPY  = 2'd1;
    localparam logic [1:0] BK_DRAIN = 2'd2;
    localparam logic [1:0] BK_OUT   = 2'd3;

    logic [1:0]           state_reg, state_next;
    job_t                 job_reg, job_next;
    logic [7:0]           cnt_reg, cnt_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [AW-1:0]        wr_pos_reg, wr_pos_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [3:0]           out_status_reg;
    logic                 out_disc_reg;
    logic [LEN_OUT_W-1:0] out_len_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_load;

    logic [7:0]    frag_mem [FRAG_SIZE];
    logic [7:0]    frag_q;
    logic          frag_re;
    logic [AW-1:0] frag_ra;

    always_comb begin
        state_next          = state_reg;
        job_next            = job_reg;
        cnt_next            = cnt_reg;
        wr_pend_next        = 1'b0;
        wr_pos_next         = wr_pos_reg;
        rd_ok_next          = rd_ok_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        pop                 = 1'b0;
        out_load            = 1'b0;
        frag_re             = 1'b0;
        frag_ra             = AW'(pop_job.read_index);
        stage_req.rd_en     = 1'b0;
        stage_req.rd_addr   = cnt_reg;
        stage_req.copy_done = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!queue_empty) begin
                    pop      = 1'b1;
                    job_next = pop_job;
                    cnt_next = '0;
                    if (pop_job.kind == JOB_COPY) begin
                        state_next = BK_COPY;
                    end else begin
                        state_next = BK_OUT;
                        if (pop_job.kind == JOB_READ) begin
                            frag_re    = 1'b1;
                            rd_ok_next = (32'(pop_job.read_index) < 32'(FRAG_SIZE));
                        end
                    end
                end
            end
            BK_COPY: begin
                stage_req.rd_en = 1'b1;
                wr_pend_next    = 1'b1;
                wr_pos_next     = AW'(job_reg.copy_base + POS_W'(cnt_reg));
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_next == job_reg.copy_len) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                stage_req.copy_done = 1'b1;
                state_next          = BK_OUT;
            end
            BK_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            wr_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wr_pend_reg  <= wr_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        cnt_reg    <= cnt_next;
        wr_pos_reg <= wr_pos_next;
        rd_ok_reg  <= rd_ok_next;
        if (out_load) begin
            out_status_reg <= job_reg.status;
            out_disc_reg   <= job_reg.fir_discarded;
            out_len_reg    <= job_reg.fragment_length;
            out_byte_reg   <= (job_reg.kind == JOB_READ && rd_ok_reg) ? frag_q : 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            frag_mem[wr_pos_reg] <= stage_rd_data;
        end
        if (frag_re) begin
            frag_q <= frag_mem[frag_ra];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_byte_reg, out_len_reg, out_disc_reg};
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

[sv/transport_segment_reassembler_unit.sv]
// top level of the transport segment reassembler: front end, job queue, back end
// depends on tsr_pkg, tsr_front, tsr_queue, tsr_back
// each request becomes a job in the front end, waits in the job queue, and the back end registers its result
// the input takes new requests while the job queue has room; after an appended segment the input holds off
// until the back end, copying one byte a cycle, has copied its payload into the fragment store
// reset: synchronous active-low aresetn clears all control state, stores are not cleared
`default_nettype none

module transport_segment_reassembler_unit
    import tsr_pkg::*;
#(
    parameter int FRAG_SIZE   = FRAG_SIZE_DEF,
    parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], read_index[18:8], zero pad
    input  logic        s_tlast,
    input  logic [2:0]  s_tuser,   // command[1:0], seg_first[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // fir_discarded[0], fragment_length[12:1], read_byte[20:13]
    output logic [3:0]  m_tuser    // status[3:0]
);

    logic       push_valid;
    job_t       push_job;
    logic       queue_full;
    logic       queue_empty;
    logic       pop;
    job_t       pop_job;
    stage_req_t stage_req;
    logic [7:0] stage_rd_data;

    tsr_front #(
        .FRAG_SIZE   (FRAG_SIZE),
        .MAX_SEGMENT (MAX_SEGMENT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .s_tuser       (s_tuser),
        .push_valid    (push_valid),
        .push_job      (push_job),
        .queue_full    (queue_full),
        .stage_req     (stage_req),
        .stage_rd_data (stage_rd_data)
    );

    tsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (queue_empty)
    );

    tsr_back #(
        .FRAG_SIZE (FRAG_SIZE)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .queue_empty   (queue_empty),
        .pop_job       (pop_job),
        .pop           (pop),
        .stage_req     (stage_req),
        .stage_rd_data (stage_rd_data),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

`default_nettype wire
